// ===== design/bse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bse_pkg;

   // command codes
   localparam logic [3:0] OP_SET        = 4'd0;
   localparam logic [3:0] OP_CLEAR      = 4'd1;
   localparam logic [3:0] OP_FLIP       = 4'd2;
   localparam logic [3:0] OP_TEST       = 4'd3;
   localparam logic [3:0] OP_SET_RANGE  = 4'd4;
   localparam logic [3:0] OP_FLIP_RANGE = 4'd5;
   localparam logic [3:0] OP_FIND_NEXT  = 4'd6;
   localparam logic [3:0] OP_COUNT      = 4'd7;
   localparam logic [3:0] OP_CLEAR_ALL  = 4'd8;
   localparam logic [3:0] OP_SET_ALL    = 4'd9;
   localparam logic [3:0] OP_FLIP_ALL   = 4'd10;

   // register index of the size register
   localparam logic CSR_IDX_BITS_IN_USE = 1'b0;
   localparam logic [12:0] BITS_IN_USE_RESET = 13'd4096;
   localparam logic [12:0] MAX_BITS = 13'd4096;

   // popcount reduction masks
   localparam logic [63:0] POP_M1 = 64'h5555555555555555;
   localparam logic [63:0] POP_M2 = 64'h3333333333333333;
   localparam logic [63:0] POP_M4 = 64'h0F0F0F0F0F0F0F0F;
   localparam logic [63:0] POP_FINAL = 64'h000000000000007F;

   // what the word unit does with one word
   typedef enum logic [2:0] {
      K_OR,
      K_XOR,
      K_CLR,
      K_TEST,
      K_FIND,
      K_COUNT
   } kind_type;

   typedef struct packed {
      logic [3:0]  op;
      logic [11:0] first_index;
      logic [12:0] end_index;
   } req_type;

   typedef struct packed {
      logic        bit_value;
      logic        found;
      logic [11:0] position;
      logic [12:0] set_count;
      logic        index_error;
   } rsp_type;

   typedef struct packed {
      kind_type   kind;
      logic [5:0] lo_bit;
      logic [5:0] hi_bit;
      logic       first_word;
      logic       last_word;
   } word_ctl_type;

   typedef struct packed {
      logic [63:0] word;
      logic        modify;
      logic        any;
      logic [5:0]  low_pos;
      logic [6:0]  pop;
   } word_res_type;

endpackage
`default_nettype wire

// ===== design/bse_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bse_mem #(
   parameter int WORD_COUNT = 64,
   parameter int AW = 6
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [63:0]   wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic [63:0]        rd_data
);

   logic [63:0] store_ff [WORD_COUNT];
   logic [63:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== design/bse_word_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bse_word_unit (
   input  wire bse_pkg::word_ctl_type ctl,
   input  wire logic [63:0]           rd_word,
   output bse_pkg::word_res_type      res
);

   logic [63:0] mask_lo;
   logic [63:0] mask_hi;
   logic [63:0] mask;
   logic [63:0] masked;
   logic [63:0] new_word;
   logic        do_write;
   logic [63:0] p1, p2, p3, p4, p5, p6;
   logic [63:0] s;
   logic [5:0]  pos;

   // bits of this word inside [lo, hi]
   always_comb begin
      mask_lo = ctl.first_word ? ({64{1'b1}} << ctl.lo_bit) : {64{1'b1}};
      mask_hi = ctl.last_word ? ({64{1'b1}} >> (6'd63 - ctl.hi_bit)) : {64{1'b1}};
      mask    = mask_lo & mask_hi;
      masked  = rd_word & mask;
   end

   always_comb begin
      new_word = rd_word;
      do_write = 1'b0;
      case (ctl.kind)
         bse_pkg::K_OR: begin
            new_word = rd_word | mask;
            do_write = 1'b1;
         end
         bse_pkg::K_XOR: begin
            new_word = rd_word ^ mask;
            do_write = 1'b1;
         end
         bse_pkg::K_CLR: begin
            new_word = rd_word & ~mask;
            do_write = 1'b1;
         end
         default: begin
            new_word = rd_word;
            do_write = 1'b0;
         end
      endcase
   end

   // swar popcount
   always_comb begin
      p1 = (masked & bse_pkg::POP_M1) + ((masked >> 1) & bse_pkg::POP_M1);
      p2 = (p1 & bse_pkg::POP_M2) + ((p1 >> 2) & bse_pkg::POP_M2);
      p3 = (p2 + (p2 >> 4)) & bse_pkg::POP_M4;
      p4 = p3 + (p3 >> 8);
      p5 = p4 + (p4 >> 16);
      p6 = (p5 + (p5 >> 32)) & bse_pkg::POP_FINAL;
   end

   // lowest set bit by halving
   always_comb begin
      s   = masked;
      pos = '0;
      if (s[31:0] == 32'd0) begin
         pos[5] = 1'b1;
         s      = s >> 32;
      end
      if (s[15:0] == 16'd0) begin
         pos[4] = 1'b1;
         s      = s >> 16;
      end
      if (s[7:0] == 8'd0) begin
         pos[3] = 1'b1;
         s      = s >> 8;
      end
      if (s[3:0] == 4'd0) begin
         pos[2] = 1'b1;
         s      = s >> 4;
      end
      if (s[1:0] == 2'd0) begin
         pos[1] = 1'b1;
         s      = s >> 2;
      end
      if (s[0] == 1'b0) begin
         pos[0] = 1'b1;
      end
   end

   always_comb begin
      res.word    = new_word;
      res.modify  = do_write;
      res.any     = (masked != 64'd0);
      res.low_pos = pos;
      res.pop     = p6[6:0];
   end

endmodule
`default_nettype wire

// ===== design/bitmap_set_engine_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// bitmap of WORD_COUNT 64-bit words held in one synchronous ram. a command is
// taken when start is high and busy is low; its single result appears on
// rsp_data for exactly one cycle with rsp_strobe high, and there is no way to
// hold it off, so the receiver must sample every strobe. commands that are
// refused (index at or past the size in use, reversed range), empty ranges,
// counts, set all or flip all at zero size, and unused codes answer straight
// from idle. set, clear, flip and test of one bit go through read,
// modify/write and result before the next accept. range, find-next, count,
// set all and flip all stream one word per cycle through the ram, touching
// at most 64 words; find-next stops at the first word holding a set bit.
// clear all writes zero to every word. after reset the block sweeps zeros
// through the ram with busy high; the size register can be written during
// that time. the ram read is registered, which sets the per-word pace: a
// word is read in one cycle and written back in the next while the
// following word is read, so a write never meets a read of the same word.
module bitmap_set_engine_unit #(
   parameter int WORD_COUNT = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // command channel
   input  wire logic             start,
   output logic                  busy,
   input  wire bse_pkg::req_type req_data,
   // result channel
   output logic                  rsp_strobe,
   output bse_pkg::rsp_type      rsp_data,
   // register port
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [2:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int AW       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   // word counter also covers the 64 words reachable by an index
   localparam int AW2      = (AW > 6) ? AW : 6;
   localparam int CAP_INT  = (WORD_COUNT * 64 < 4096) ? WORD_COUNT * 64 : 4096;
   localparam logic [12:0]    SIZE_CAP  = 13'(CAP_INT);
   localparam logic [AW2-1:0] LAST_WORD = AW2'(WORD_COUNT - 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type             state_ff, state_in;
   logic [AW2-1:0]        rd_ff, rd_in;         // next word to read / clear
   logic [AW2-1:0]        wb_ff, wb_in;         // word whose data is back
   logic                  pend_ff, pend_in;     // read data valid this cycle
   logic                  issued_all_ff, issued_all_in;
   bse_pkg::kind_type     kind_ff, kind_in;
   logic [11:0]           lo_ff, lo_in;         // first bit of the span
   logic [11:0]           him1_ff, him1_in;     // last bit of the span
   logic [12:0]           cnt_ff, cnt_in;
   logic                  clr_rsp_ff, clr_rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   bse_pkg::rsp_type      rsp_ff, rsp_in;
   logic [12:0]           bits_ff, bits_in;

   logic [12:0]           size;
   logic [12:0]           size_m1;
   logic [12:0]           end_m1;
   logic                  first_bad;
   logic                  range_bad;
   logic                  scan_go;
   logic                  done;
   logic                  csr_wr;

   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [63:0]           mem_wdata;
   logic [63:0]           mem_rdata;

   bse_pkg::word_ctl_type wctl;
   bse_pkg::word_res_type wres;

   bse_mem #(
      .WORD_COUNT(WORD_COUNT),
      .AW        (AW)
   ) u_mem (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(rd_ff[AW-1:0]),
      .rd_data(mem_rdata)
   );

   bse_word_unit u_word (
      .ctl    (wctl),
      .rd_word(mem_rdata),
      .res    (wres)
   );

   // size in use, capped by the storage
   assign size      = (bits_ff > SIZE_CAP) ? SIZE_CAP : bits_ff;
   assign size_m1   = size - 13'd1;
   assign end_m1    = req_data.end_index - 13'd1;
   assign first_bad = ({1'b0, req_data.first_index} >= size);
   assign range_bad = (req_data.end_index > size)
                   || ({1'b0, req_data.first_index} > req_data.end_index);

   // register port: one register, no wait states
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && (paddr[2] == bse_pkg::CSR_IDX_BITS_IN_USE);
   assign bits_in = csr_wr ? pwdata[12:0] : bits_ff;
   assign prdata  = (paddr[2] == bse_pkg::CSR_IDX_BITS_IN_USE) ? 32'(bits_ff) : 32'd0;

   // word unit sees the word whose data just came back
   always_comb begin
      wctl.kind       = kind_ff;
      wctl.lo_bit     = lo_ff[5:0];
      wctl.hi_bit     = him1_ff[5:0];
      wctl.first_word = (wb_ff == AW2'(lo_ff[11:6]));
      wctl.last_word  = (wb_ff == AW2'(him1_ff[11:6]));
   end

   always_comb begin
      state_in      = state_ff;
      rd_in         = rd_ff;
      wb_in         = rd_ff;
      pend_in       = 1'b0;
      issued_all_in = issued_all_ff;
      kind_in       = kind_ff;
      lo_in         = lo_ff;
      him1_in       = him1_ff;
      cnt_in        = cnt_ff;
      clr_rsp_in    = clr_rsp_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      scan_go       = 1'b0;
      done          = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = wb_ff[AW-1:0];
      mem_wdata     = wres.word;

      case (state_ff)
         ST_CLEAR: begin
            // zero sweep, after reset or for clear all
            mem_we    = 1'b1;
            mem_waddr = rd_ff[AW-1:0];
            mem_wdata = 64'd0;
            rd_in     = rd_ff + AW2'(1);
            if (rd_ff == LAST_WORD) begin
               state_in   = ST_IDLE;
               clr_rsp_in = 1'b0;
               if (clr_rsp_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
               end
            end
         end

         ST_IDLE: begin
            if (start) begin
               rsp_in = '0;
               case (req_data.op)
                  bse_pkg::OP_SET, bse_pkg::OP_CLEAR,
                  bse_pkg::OP_FLIP, bse_pkg::OP_TEST: begin
                     if (first_bad) begin
                        rsp_valid_in       = 1'b1;
                        rsp_in.index_error = 1'b1;
                     end else begin
                        scan_go = 1'b1;
                        lo_in   = req_data.first_index;
                        him1_in = req_data.first_index;
                        case (req_data.op)
                           bse_pkg::OP_SET:   kind_in = bse_pkg::K_OR;
                           bse_pkg::OP_CLEAR: kind_in = bse_pkg::K_CLR;
                           bse_pkg::OP_FLIP:  kind_in = bse_pkg::K_XOR;
                           default:           kind_in = bse_pkg::K_TEST;
                        endcase
                     end
                  end
                  bse_pkg::OP_SET_RANGE, bse_pkg::OP_FLIP_RANGE: begin
                     if (range_bad) begin
                        rsp_valid_in       = 1'b1;
                        rsp_in.index_error = 1'b1;
                     end else if ({1'b0, req_data.first_index} == req_data.end_index) begin
                        // empty range
                        rsp_valid_in = 1'b1;
                     end else begin
                        scan_go = 1'b1;
                        lo_in   = req_data.first_index;
                        him1_in = end_m1[11:0];
                        kind_in = (req_data.op == bse_pkg::OP_SET_RANGE) ?
                                  bse_pkg::K_OR : bse_pkg::K_XOR;
                     end
                  end
                  bse_pkg::OP_FIND_NEXT: begin
                     if (first_bad) begin
                        rsp_valid_in       = 1'b1;
                        rsp_in.index_error = 1'b1;
                     end else begin
                        scan_go = 1'b1;
                        lo_in   = req_data.first_index;
                        him1_in = size_m1[11:0];
                        kind_in = bse_pkg::K_FIND;
                     end
                  end
                  bse_pkg::OP_COUNT, bse_pkg::OP_SET_ALL, bse_pkg::OP_FLIP_ALL: begin
                     if (size == 13'd0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        scan_go = 1'b1;
                        lo_in   = 12'd0;
                        him1_in = size_m1[11:0];
                        case (req_data.op)
                           bse_pkg::OP_COUNT:   kind_in = bse_pkg::K_COUNT;
                           bse_pkg::OP_SET_ALL: kind_in = bse_pkg::K_OR;
                           default:             kind_in = bse_pkg::K_XOR;
                        endcase
                     end
                  end
                  bse_pkg::OP_CLEAR_ALL: begin
                     // clears bits past the size too
                     state_in   = ST_CLEAR;
                     rd_in      = '0;
                     clr_rsp_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
               if (scan_go) begin
                  state_in      = ST_SCAN;
                  rd_in         = AW2'(lo_in[11:6]);
                  issued_all_in = 1'b0;
                  cnt_in        = 13'd0;
               end
            end
         end

         ST_SCAN: begin
            // read side: one word per cycle up to the last word of the span
            if (!issued_all_ff) begin
               rd_in         = rd_ff + AW2'(1);
               pend_in       = 1'b1;
               issued_all_in = (rd_ff == AW2'(him1_ff[11:6]));
            end
            // data side: modify and write back the word read last cycle
            if (pend_ff) begin
               mem_we = wres.modify;
               case (kind_ff)
                  bse_pkg::K_FIND: begin
                     if (wres.any) begin
                        done            = 1'b1;
                        rsp_in.found    = 1'b1;
                        rsp_in.position = {wb_ff[5:0], wres.low_pos};
                     end else if (wctl.last_word) begin
                        done = 1'b1;
                     end
                  end
                  bse_pkg::K_TEST: begin
                     done             = 1'b1;
                     rsp_in.bit_value = wres.any;
                  end
                  bse_pkg::K_COUNT: begin
                     cnt_in = cnt_ff + 13'(wres.pop);
                     if (wctl.last_word) begin
                        done             = 1'b1;
                        rsp_in.set_count = cnt_ff + 13'(wres.pop);
                     end
                  end
                  default: begin
                     done = wctl.last_word;
                  end
               endcase
            end
            if (done) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               pend_in      = 1'b0;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         rd_ff         <= '0;
         pend_ff       <= 1'b0;
         issued_all_ff <= 1'b0;
         clr_rsp_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         bits_ff       <= bse_pkg::BITS_IN_USE_RESET;
      end else begin
         state_ff      <= state_in;
         rd_ff         <= rd_in;
         pend_ff       <= pend_in;
         issued_all_ff <= issued_all_in;
         clr_rsp_ff    <= clr_rsp_in;
         rsp_valid_ff  <= rsp_valid_in;
         bits_ff       <= bits_in;
      end
      wb_ff   <= wb_in;
      kind_ff <= kind_in;
      lo_ff   <= lo_in;
      him1_ff <= him1_in;
      cnt_ff  <= cnt_in;
      rsp_ff  <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // ram is never written while waiting for a command
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff != ST_IDLE))
      else $error("ram written while idle");

   // the block stays busy right after reset for the zero sweep
   a_busy_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> busy)
      else $error("not busy after reset");

   // words come back in order and never past the end of the span
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && pend_ff |-> (wb_ff <= AW2'(him1_ff[11:6])))
      else $error("scan ran past last word");

   // a refused command reports nothing else
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.index_error |->
         !rsp_data.found && !rsp_data.bit_value
         && (rsp_data.set_count == 13'd0) && (rsp_data.position == 12'd0))
      else $error("error result carries data");

endmodule
`default_nettype wire
